@@ sv/xsm_pkg.sv @@
// Shared types and constants for the XOR span membership block.
`timescale 1ns / 1ps

package xsm_pkg;

    localparam int DEF_WORD_BITS = 64;
    localparam int VALUE_W       = 64;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } xsm_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } xsm_status_t;

endpackage

@@ sv/xsm_ctrl.sv @@
// Sequencer that walks the basis slots for one item at a time.
`timescale 1ns / 1ps

module xsm_ctrl
    import xsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  xsm_status_t status,
    output xsm_cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold the finished item until the output register is free.
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/xsm_datapath.sv @@
// Remainder register, basis memory with slot valid bits, and result register.
`timescale 1ns / 1ps

module xsm_datapath
    import xsm_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op,
    input  logic [VALUE_W-1:0] value,
    input  xsm_cmd_t           cmd,
    output xsm_status_t        status,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               in_span
);

    localparam int IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [WORD_BITS-1:0] basis_mem [WORD_BITS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;

    logic [WORD_BITS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic                 op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     lead_reg;
    logic                 lead_found_reg;
    logic                 out_valid_reg;
    logic                 in_span_reg;

    logic                 rem_bit;
    logic                 rem_zero;
    logic                 do_store;

    // The next slot is fetched into the read register in the cycle before its use.
    assign rd_addr  = cmd.load ? IDX_W'(WORD_BITS - 1) : idx_reg - IDX_W'(1);
    assign rem_bit  = rem_reg[idx_reg];
    assign rem_zero = (rem_reg == '0);
    assign do_store = cmd.commit && (op_reg == OP_ADD) && !rem_zero;

    assign status.last     = (idx_reg == '0);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign in_span   = in_span_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= basis_mem[rd_addr];
        if (do_store)
        begin
            basis_mem[lead_reg] <= rem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= value[WORD_BITS-1:0];
            op_reg  <= op;
        end
        else if (cmd.step && rem_bit && valid_reg[idx_reg])
        begin
            rem_reg <= rem_reg ^ rd_data_reg;
        end
        if (cmd.commit)
        begin
            in_span_reg <= rem_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            idx_reg        <= '0;
            lead_reg       <= '0;
            lead_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg        <= IDX_W'(WORD_BITS - 1);
                lead_found_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg - IDX_W'(1);
                // The highest set bit without a basis word becomes the new slot.
                if (rem_bit && !valid_reg[idx_reg] && !lead_found_reg)
                begin
                    lead_reg       <= idx_reg;
                    lead_found_reg <= 1'b1;
                end
            end
            if (do_store)
            begin
                valid_reg[lead_reg] <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ sv/xor_span_membership.sv @@
// Each item is walked over the basis memory, one slot per cycle through its single
// registered read port, and the next item is taken only once the last is committed.
// The result register frees the output side, so the next item is taken while
// a result still waits. Reset empties the basis at once through per-slot valid bits.
`timescale 1ns / 1ps

module xor_span_membership
    import xsm_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               in_span
);

    xsm_cmd_t    cmd;
    xsm_status_t status;

    xsm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    xsm_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .in_span   (in_span)
    );

endmodule
